// ----- hdl/pfl_pkg.sv -----
`default_nettype none

package pfl_pkg;

   localparam int unsigned FieldWidth = 29;

   // one request: a message byte and its end mark
   typedef struct packed {
      logic [7:0] msg_byte;
      logic       last_byte;
   } pfl_req_type;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_NOTFOUND  = 2'd1,
      ST_MALFORMED = 2'd2
   } pfl_status_type;

   typedef struct packed {
      logic [7:0]     data_byte;
      logic           in_payload;
      logic           done_res;
      pfl_status_type status;
      logic [31:0]    found_len;
   } pfl_result_type;

   typedef enum logic [6:0] {
      PH_TAG     = 7'b000_0001,
      PH_VSKIP   = 7'b000_0010,
      PH_LEN     = 7'b000_0100,
      PH_SKIP    = 7'b000_1000,
      PH_WLEN    = 7'b001_0000,
      PH_PAYLOAD = 7'b010_0000,
      PH_DONE    = 7'b100_0000
   } pfl_phase_type;

   localparam logic [2:0] WireVarint = 3'd0;
   localparam logic [2:0] WireLen    = 3'd2;
   localparam int unsigned VarintMaxBytes = 5;

endpackage

`default_nettype wire

// ----- hdl/protobuf_field_locator.sv -----
// protobuf_field_locator
// Scans a protobuf wire-format message, one byte per request, and flags the
// payload bytes of the length-delimited field whose tag is wanted_field*8+2.
// Request channel (req_*): req_msg_byte plus req_last_byte marking the final
// byte; taken when req_valid is high and req_stall is low.
// Response channel (rsp_*): exactly one response per request, carrying the byte,
// its in_payload flag and, on the byte that decides it, a done_res pulse with
// status (found / not found / malformed) and found_len.
// CSR channel (csr_*): writes wanted_field; csr_ready is always high. Write only
// while no request is in flight.
// A taken request passes the request register, then the response register, on
// its way to rsp_*. Throughput is one byte per clock while rsp_stall is low: the
// parser is one pass of logic between them, with no feedback wider than a byte step.
// A stalled receiver holds the response register; one more request is absorbed
// in the request register, after which req_stall follows rsp_stall directly.
// Reset (synchronous, active high) empties both registers, returns the parser to
// reading a tag and sets wanted_field to 1.
`default_nettype none

module protobuf_field_locator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_msg_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_in_payload,
   output logic             rsp_done_res,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_found_len,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [28:0] csr_wanted_field
);
   import pfl_pkg::*;

   // wanted field number, written through the CSR channel
   logic [FieldWidth-1:0] wanted_field_ff;

   pfl_req_type    req_item, s1_item;
   logic           s1_valid, s2_ready, fire;
   pfl_result_type s2_result, rsp_result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_field_ff <= FieldWidth'(1);
      end else if (csr_valid && csr_ready) begin
         wanted_field_ff <= csr_wanted_field;
      end
   end

   assign req_item.msg_byte  = req_msg_byte;
   assign req_item.last_byte = req_last_byte;

   pfl_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item),
      .s1_take   (fire)
   );

   // parser state advances exactly when a byte moves into the response register
   assign fire = s1_valid && s2_ready;

   pfl_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (s1_item),
      .wanted_field (wanted_field_ff),
      .result       (s2_result)
   );

   pfl_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .s2_valid   (s1_valid),
      .s2_result  (s2_result),
      .s2_ready   (s2_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_data_byte  = rsp_result.data_byte;
   assign rsp_in_payload = rsp_result.in_payload;
   assign rsp_done_res   = rsp_result.done_res;
   assign rsp_status     = rsp_result.status;
   assign rsp_found_len  = rsp_result.found_len;

   // a length is reported only with a found outcome
   a_len_only_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_found_len != 32'd0) |->
         rsp_done_res && (rsp_status == ST_FOUND))
      else $error("found_len without found done");

   // status stays zero between outcomes
   a_status_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == ST_FOUND)
      else $error("status set without done");

   // a payload byte can only end a message as found or cut off
   a_payload_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_payload && rsp_done_res |->
         (rsp_status == ST_FOUND) || (rsp_status == ST_MALFORMED))
      else $error("payload byte reported as not found");

   // the parser never advances while the request register is empty
   a_fire_valid: assert property (@(posedge clock) disable iff (reset)
      fire |-> s1_valid && s2_ready)
      else $error("parser advanced without a request");

endmodule

`default_nettype wire

// ----- hdl/pfl_in_stage.sv -----
`default_nettype none

module pfl_in_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire pfl_pkg::pfl_req_type req_item,
   output logic                     s1_valid,
   output pfl_pkg::pfl_req_type     s1_item,
   input  wire logic                s1_take
);
   import pfl_pkg::*;

   logic        valid_ff, valid_in;
   pfl_req_type item_ff;
   logic        load;

   assign req_stall = valid_ff && !s1_take;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !s1_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_item  = item_ff;

endmodule

`default_nettype wire

// ----- hdl/pfl_parser.sv -----
`default_nettype none

module pfl_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire pfl_pkg::pfl_req_type     item,
   input  wire logic [28:0]              wanted_field,
   output pfl_pkg::pfl_result_type       result
);
   import pfl_pkg::*;

   pfl_phase_type  phase_ff, phase_in;
   logic [31:0]    acc_ff, acc_in;
   logic [2:0]     cnt_ff, cnt_in;
   logic [31:0]    skip_ff, skip_in;
   logic [31:0]    flen_ff, flen_in;

   logic [2:0]     k;
   logic [6:0]     b7;
   logic [31:0]    shifted, fed_acc;
   logic           more, too_long, done;
   pfl_status_type status;
   logic [31:0]    plen;
   logic           pay;

   assign b7       = item.msg_byte[6:0];
   assign more     = item.msg_byte[7];
   assign k        = (cnt_ff > 3'd4) ? 3'd4 : cnt_ff;
   assign too_long = more && ((k + 3'd1) >= 3'(VarintMaxBytes));

   // place 7 payload bits at bit 7k; bits past 31 are dropped
   always_comb begin
      case (k)
         3'd0:    shifted = {25'b0, b7};
         3'd1:    shifted = {18'b0, b7, 7'b0};
         3'd2:    shifted = {11'b0, b7, 14'b0};
         3'd3:    shifted = {4'b0, b7, 21'b0};
         default: shifted = {b7[3:0], 28'b0};
      endcase
   end

   assign fed_acc = acc_ff | shifted;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      skip_in  = skip_ff;
      flen_in  = flen_ff;
      done     = 1'b0;
      status   = ST_FOUND;
      plen     = '0;
      pay      = 1'b0;

      unique case (phase_ff)
         PH_TAG, PH_VSKIP, PH_LEN, PH_WLEN: begin
            if (more) begin
               acc_in = fed_acc;
               cnt_in = k + 3'd1;
               if (too_long) begin
                  done   = 1'b1;
                  status = ST_MALFORMED;
               end
            end else begin
               acc_in = '0;
               cnt_in = '0;
               unique case (phase_ff)
                  PH_TAG: begin
                     if (fed_acc == {wanted_field, WireLen}) begin
                        phase_in = PH_WLEN;
                     end else if (fed_acc[2:0] == WireVarint) begin
                        phase_in = PH_VSKIP;
                     end else if (fed_acc[2:0] == WireLen) begin
                        phase_in = PH_LEN;
                     end else begin
                        done   = 1'b1;
                        status = ST_MALFORMED;
                     end
                  end
                  PH_VSKIP: begin
                     phase_in = PH_TAG;
                  end
                  PH_LEN: begin
                     if (fed_acc == '0) begin
                        phase_in = PH_TAG;
                     end else begin
                        skip_in  = fed_acc;
                        phase_in = PH_SKIP;
                     end
                  end
                  default: begin
                     flen_in = fed_acc;
                     if (fed_acc == '0) begin
                        done   = 1'b1;
                        status = ST_FOUND;
                     end else begin
                        skip_in  = fed_acc;
                        phase_in = PH_PAYLOAD;
                     end
                  end
               endcase
            end
         end
         PH_SKIP: begin
            skip_in = skip_ff - 32'd1;
            if (skip_ff == 32'd1) begin
               phase_in = PH_TAG;
            end
         end
         PH_PAYLOAD: begin
            pay     = 1'b1;
            skip_in = skip_ff - 32'd1;
            if (skip_ff == 32'd1) begin
               done   = 1'b1;
               status = ST_FOUND;
               plen   = flen_ff;
            end
         end
         default: ;
      endcase

      if (done) begin
         phase_in = PH_DONE;
      end

      if (item.last_byte) begin
         if (phase_in != PH_DONE) begin
            done   = 1'b1;
            status = (phase_in == PH_TAG && cnt_in == 3'd0) ? ST_NOTFOUND : ST_MALFORMED;
         end
         phase_in = PH_TAG;
         acc_in   = '0;
         cnt_in   = '0;
         skip_in  = '0;
         flen_in  = '0;
      end

      result.data_byte  = item.msg_byte;
      result.in_payload = pay;
      result.done_res   = done;
      result.status     = done ? status : ST_FOUND;
      result.found_len  = (done && status == ST_FOUND) ? plen : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         skip_ff  <= '0;
         flen_ff  <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         skip_ff  <= skip_in;
         flen_ff  <= flen_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/pfl_out_stage.sv -----
`default_nettype none

module pfl_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   s2_valid,
   input  wire pfl_pkg::pfl_result_type s2_result,
   output logic                        s2_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output pfl_pkg::pfl_result_type     rsp_result
);
   import pfl_pkg::*;

   logic           valid_ff, valid_in;
   pfl_result_type result_ff;
   logic           load;

   assign s2_ready = !valid_ff || !rsp_stall;
   assign load     = s2_valid && s2_ready;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= s2_result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire
